// ===== src/hud_pkg.sv =====
// ----------------------------------------------------------------------------
// HCI UART deframer package
// Shared types and constants for the H4 receive-side deframer.
// ----------------------------------------------------------------------------
package hud_pkg;

  localparam logic [7:0]  TypeAcl     = 8'h02;
  localparam logic [7:0]  TypeEvent   = 8'h04;
  localparam logic [15:0] MaxLenReset = 16'd1024;

  localparam logic [1:0]  EventHdrLastPos = 2'd1;
  localparam logic [1:0]  AclHdrLastPos   = 2'd3;
  localparam logic [1:0]  AclLenLoPos     = 2'd2;
  localparam logic [1:0]  AclLenHiPos     = 2'd3;

  localparam logic KindEvent = 1'b0;
  localparam logic KindAcl   = 1'b1;

  typedef struct packed {
    logic [7:0] rx_byte;
  } rx_beat_t;

  typedef struct packed {
    logic [15:0] max_payload_len;
  } cfg_beat_t;

  typedef struct packed {
    logic       packet_kind;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       oversize_error;
  } pkt_beat_t;

  typedef struct packed {
    logic     valid;
    rx_beat_t beat;
  } rx_slot_t;

endpackage

// ===== src/hud_stream_if.sv =====
// ----------------------------------------------------------------------------
// Stream interface
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface hud_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/hci_uart_packet_deframer.sv =====
// ----------------------------------------------------------------------------
// HCI UART packet deframer
// Splits a received H4 byte stream into event and ACL packet beats.
//
//   port   dir  beat         contents
//   rx_i   in   rx_beat_t    rx_byte
//   cfg_i  in   cfg_beat_t   max_payload_len
//   pkt_o  out  pkt_beat_t   packet_kind, data_byte, last_byte, oversize_error
//
// One byte per cycle unless pkt_o stalls; each byte is held in the input
// register and its result in the result register.
// Reset clears all framing state and loads max_payload_len with 1024.
// A stalled pkt_o holds both registers, bytes that yield no beat included.
// cfg_i is always ready and registers each write into max_payload_len.
// ----------------------------------------------------------------------------
module hci_uart_packet_deframer (
  input  logic         clk_i,
  input  logic         rst_ni,
  hud_stream_if.sink   rx_i,
  hud_stream_if.sink   cfg_i,
  hud_stream_if.source pkt_o
);
  import hud_pkg::*;

  logic [15:0] max_len_q;
  rx_slot_t    slot;
  logic        advance;
  logic        res_valid;
  pkt_beat_t   res;
  rx_beat_t    rx_beat;
  cfg_beat_t   cfg_beat;
  pkt_beat_t   pkt_beat;

  assign rx_beat     = rx_i.payload;
  assign cfg_beat    = cfg_i.payload;
  assign cfg_i.ready = 1'b1;
  assign pkt_o.payload = pkt_beat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
    end else if (cfg_i.valid) begin
      max_len_q <= cfg_beat.max_payload_len;
    end
  end

  hud_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rx_i.valid),
    .in_beat_i  (rx_beat),
    .in_ready_o (rx_i.ready),
    .advance_i  (advance),
    .slot_o     (slot)
  );

  hud_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .slot_i      (slot),
    .advance_i   (advance),
    .max_len_i   (max_len_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  hud_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .free_o      (advance),
    .out_valid_o (pkt_o.valid),
    .out_beat_o  (pkt_beat),
    .out_ready_i (pkt_o.ready)
  );
endmodule

// ===== src/hud_in_stage.sv =====
// ----------------------------------------------------------------------------
// Input register
// Holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module hud_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  hud_pkg::rx_beat_t in_beat_i,
  output logic              in_ready_o,
  input  logic              advance_i,
  output hud_pkg::rx_slot_t slot_o
);
  import hud_pkg::*;

  logic     valid_q;
  rx_beat_t beat_q;

  assign in_ready_o = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      beat_q <= in_beat_i;
    end
  end

  assign slot_o.valid = valid_q;
  assign slot_o.beat  = beat_q;
endmodule

// ===== src/hud_parser.sv =====
// ----------------------------------------------------------------------------
// Packet parser
// Tracks type/header/payload phases; a result per header or kept payload byte.
// ----------------------------------------------------------------------------
module hud_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hud_pkg::rx_slot_t  slot_i,
  input  logic               advance_i,
  input  logic [15:0]        max_len_i,
  output logic               res_valid_o,
  output hud_pkg::pkt_beat_t res_o
);
  import hud_pkg::*;

  typedef enum logic [1:0] {
    PhType,
    PhHeader,
    PhPayload
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [1:0]  hdr_cnt_q, hdr_cnt_d;
  logic [15:0] len_q, len_d;
  logic [15:0] remain_q, remain_d;
  logic        kind_q, kind_d;
  logic        drop_q, drop_d;

  logic [7:0]  b;
  logic        hdr_final;
  logic        pay_last;

  assign b = slot_i.beat.rx_byte;

  always_comb begin
    phase_d     = phase_q;
    hdr_cnt_d   = hdr_cnt_q;
    len_d       = len_q;
    remain_d    = remain_q;
    kind_d      = kind_q;
    drop_d      = drop_q;
    res_valid_o = 1'b0;
    res_o.packet_kind    = kind_q;
    res_o.data_byte      = b;
    res_o.last_byte      = 1'b0;
    res_o.oversize_error = 1'b0;
    hdr_final   = 1'b0;
    pay_last    = 1'b0;

    unique case (phase_q)
      PhHeader: begin
        res_valid_o = 1'b1;
        if (kind_q == KindAcl) begin
          if (hdr_cnt_q == AclLenLoPos) begin
            len_d = {len_q[15:8], b};
          end else if (hdr_cnt_q == AclLenHiPos) begin
            len_d = {b, len_q[7:0]};
          end
          hdr_final = (hdr_cnt_q == AclHdrLastPos);
        end else begin
          if (hdr_cnt_q == EventHdrLastPos) begin
            len_d = {8'h00, b};
          end
          hdr_final = (hdr_cnt_q >= EventHdrLastPos);
        end
        if (hdr_final) begin
          hdr_cnt_d = 2'd0;
          priority if (len_d > max_len_i) begin
            res_o.last_byte      = 1'b1;
            res_o.oversize_error = 1'b1;
            drop_d    = 1'b1;
            remain_d  = len_d;
            phase_d   = PhPayload;
          end else if (len_d == 16'd0) begin
            res_o.last_byte = 1'b1;
            drop_d    = 1'b0;
            remain_d  = 16'd0;
            phase_d   = PhType;
          end else begin
            drop_d    = 1'b0;
            remain_d  = len_d;
            phase_d   = PhPayload;
          end
        end else begin
          hdr_cnt_d = hdr_cnt_q + 2'd1;
        end
      end
      PhPayload: begin
        pay_last        = (remain_q <= 16'd1);
        res_valid_o     = !drop_q;
        res_o.last_byte = pay_last;
        if (pay_last) begin
          remain_d = 16'd0;
          drop_d   = 1'b0;
          phase_d  = PhType;
        end else begin
          remain_d = remain_q - 16'd1;
        end
      end
      default: begin
        hdr_cnt_d = 2'd0;
        len_d     = 16'd0;
        remain_d  = 16'd0;
        drop_d    = 1'b0;
        if (b == TypeEvent) begin
          kind_d  = KindEvent;
          phase_d = PhHeader;
        end else if (b == TypeAcl) begin
          kind_d  = KindAcl;
          phase_d = PhHeader;
        end else begin
          phase_d = PhType;
        end
      end
    endcase

    if (!slot_i.valid) begin
      res_valid_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhType;
      hdr_cnt_q <= 2'd0;
      len_q     <= 16'd0;
      remain_q  <= 16'd0;
      kind_q    <= 1'b0;
      drop_q    <= 1'b0;
    end else if (advance_i && slot_i.valid) begin
      phase_q   <= phase_d;
      hdr_cnt_q <= hdr_cnt_d;
      len_q     <= len_d;
      remain_q  <= remain_d;
      kind_q    <= kind_d;
      drop_q    <= drop_d;
    end
  end
endmodule

// ===== src/hud_out_stage.sv =====
// ----------------------------------------------------------------------------
// Result register
// Holds one packet beat until the downstream sink takes it.
// ----------------------------------------------------------------------------
module hud_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               res_valid_i,
  input  hud_pkg::pkt_beat_t res_i,
  output logic               free_o,
  output logic               out_valid_o,
  output hud_pkg::pkt_beat_t out_beat_o,
  input  logic               out_ready_i
);
  import hud_pkg::*;

  logic      valid_q;
  pkt_beat_t beat_q;

  assign free_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && res_valid_i) begin
      beat_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_beat_o  = beat_q;
endmodule
